// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared assertion wrappers for the bracket rank core
// clocked on i_clk; BSR_ASSERT is quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define BSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/core/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants
// table geometry, symbol codes and the control groups passed between units
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int MAX_PAIRS   = 16;
    localparam int HL_W        = 5;
    localparam int SYM_W       = 2;
    localparam int RANK_W      = 60;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 64;

    localparam int TAB_ROWS    = 2 * MAX_PAIRS + 1;
    localparam int TAB_COLS    = MAX_PAIRS + 2;
    localparam int TAB_DEPTH   = TAB_ROWS * TAB_COLS;
    localparam int TAB_AW      = $clog2(TAB_DEPTH);
    localparam int ROW_W       = $clog2(TAB_ROWS);
    localparam int COL_W       = $clog2(TAB_COLS);
    localparam int POS_W       = $clog2(2 * MAX_PAIRS + 1);
    localparam int R_W         = $clog2(2 * MAX_PAIRS);
    localparam int CMP_W       = POS_W + 1;
    localparam int DEP_W       = $clog2(MAX_PAIRS + 1);
    localparam int STK_AW      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int SH_W        = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic TYPE_RND = 1'b0;
    localparam logic TYPE_SQR = 1'b1;

    typedef enum logic [SYM_W-1:0] {
        SYM_OPEN_RND  = 2'd0,
        SYM_CLOSE_RND = 2'd1,
        SYM_OPEN_SQR  = 2'd2,
        SYM_CLOSE_SQR = 2'd3
    } t_symbol;

    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] addr;
        logic [RANK_W-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic            valid;
        logic            last;
        logic            bad;
        logic            add_x;
        logic            dbl_x;
        logic            add_y;
        logic            zero_x;
        logic            zero_y;
        logic [SH_W-1:0] sh_x;
        logic [SH_W-1:0] sh_y;
    } t_issue;

endpackage

// File: rtl/core/bsr_ram.sv
// ----------------------------------------------------------------------------
// bsr_ram: generic single-clock ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bsr_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bsr_fill.sv
// ----------------------------------------------------------------------------
// bsr_fill: path count table builder
// sweeps the table one entry a cycle, each row derived from the row above
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsr_fill import bsr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output t_tbl_wr o_wr
);

    typedef enum logic [2:0] {
        FS_START = 3'b001,
        FS_RUN   = 3'b010,
        FS_IDLE  = 3'b100
    } t_fill_state;

    t_fill_state       r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [RANK_W-1:0] r_prev [TAB_COLS];
    logic [RANK_W-1:0] n_prev [TAB_COLS];
    logic              col_end;
    logic              row_end;

    assign col_end = (r_col == COL_W'(TAB_COLS - 1));
    assign row_end = (r_row == ROW_W'(TAB_ROWS - 1));

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        for (int j = 0; j < TAB_COLS; j++) begin
            n_prev[j] = r_prev[j];
        end
        case (r_state)
            FS_START: begin
                n_row = '0;
                n_col = '0;
                for (int j = 0; j < TAB_COLS; j++) begin
                    n_prev[j] = (j == 0) ? RANK_W'(1) : '0;
                end
                n_state = FS_RUN;
            end
            FS_RUN: begin
                if (col_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_state = FS_IDLE;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                        // next row: paths step up or down from the row above
                        for (int j = 0; j < TAB_COLS; j++) begin
                            n_prev[j] = ((j > 0) ? r_prev[(j > 0) ? j - 1 : 0] : '0)
                                      + ((j + 1 < TAB_COLS) ?
                                         r_prev[(j + 1 < TAB_COLS) ? j + 1 : j] : '0);
                        end
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            FS_IDLE: begin
                n_state = FS_IDLE;
            end
            default: begin
                n_state = FS_START;
            end
        endcase
        if (i_start) begin
            n_state = FS_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_START;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < TAB_COLS; j++) begin
            r_prev[j] <= n_prev[j];
        end
    end

    assign o_busy    = (r_state != FS_IDLE);
    assign o_wr.we   = (r_state == FS_RUN);
    assign o_wr.addr = TAB_AW'(r_row) * TAB_AW'(TAB_COLS) + TAB_AW'(r_col);
    assign o_wr.data = r_prev[r_col];

    `BSR_ASSERT(a_fill_addr_range, o_wr.we |-> (o_wr.addr < TAB_AW'(TAB_DEPTH)), "table write beyond depth")
    `BSR_ASSERT(a_fill_restart, i_start |=> (o_busy && !o_wr.we), "fill did not restart on start")

endmodule

// File: rtl/core/bsr_issue.sv
// ----------------------------------------------------------------------------
// bsr_issue: symbol front end
// tracks position, depth, error and the bracket type stack, and issues
// the two table reads with the add plan for each accepted item
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsr_issue import bsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [HL_W-1:0]   i_cfg_wdata,
    input  logic              i_busy,
    input  logic              i_valid,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_room,
    output logic              o_ready,
    output logic              o_last_acc,
    output logic [TAB_AW-1:0] o_addr_x,
    output logic [TAB_AW-1:0] o_addr_y,
    output t_issue            o_iss
);

    logic [HL_W-1:0]      r_hl;
    logic [POS_W-1:0]     r_pos;
    logic [DEP_W-1:0]     r_depth;
    logic                 r_err;
    logic [MAX_PAIRS-1:0] r_stack;
    t_issue               r_iss;

    logic [HL_W-1:0]  cfg_hl;
    logic [POS_W-1:0] total;
    logic             is_last;
    logic             acc;
    logic [R_W-1:0]   rem;
    logic [COL_W-1:0] hx;
    logic [COL_W-1:0] hy;
    logic [DEP_W-1:0] hm1;
    logic [CMP_W-1:0] d_x;
    logic [CMP_W-1:0] d_y;
    logic             top;
    logic             full;
    logic             empty;
    t_symbol          sym;
    logic             n_err_s;
    logic [DEP_W-1:0] n_depth_s;
    logic             push;
    logic             push_bit;
    logic             add_x;
    logic             dbl_x;
    logic             add_y;

    always_comb begin
        cfg_hl = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_hl = HL_W'(1);
        end else if (i_cfg_wdata > HL_W'(MAX_PAIRS)) begin
            cfg_hl = HL_W'(MAX_PAIRS);
        end
    end

    assign total      = POS_W'({r_hl, 1'b0});
    assign is_last    = (r_pos == total - POS_W'(1));
    assign o_ready    = !i_busy && (!is_last || i_room);
    assign acc        = i_valid && o_ready;
    assign o_last_acc = acc && is_last;

    assign rem   = R_W'(total - r_pos - POS_W'(1));
    assign hx    = COL_W'(r_depth) + COL_W'(1);
    assign hy    = COL_W'(r_depth) - COL_W'(1);
    assign hm1   = r_depth - DEP_W'(1);
    assign top   = r_stack[hm1[STK_AW-1:0]];
    assign full  = (r_depth >= DEP_W'(MAX_PAIRS));
    assign empty = (r_depth == '0);
    assign sym   = t_symbol'(i_symbol);

    // remaining length minus target height: sign says no completion, half is the type shift
    assign d_x = CMP_W'(rem) - CMP_W'(hx);
    assign d_y = CMP_W'(rem) - CMP_W'(hy);

    assign o_addr_x = TAB_AW'(rem) * TAB_AW'(TAB_COLS) + TAB_AW'(hx);
    assign o_addr_y = TAB_AW'(rem) * TAB_AW'(TAB_COLS) + TAB_AW'(hy);

    always_comb begin
        n_err_s   = r_err;
        n_depth_s = r_depth;
        push      = 1'b0;
        push_bit  = TYPE_RND;
        add_x     = 1'b0;
        dbl_x     = 1'b0;
        add_y     = 1'b0;
        if (!r_err) begin
            case (sym)
                SYM_OPEN_RND: begin
                    if (full) begin
                        n_err_s = 1'b1;
                    end else begin
                        push      = 1'b1;
                        push_bit  = TYPE_RND;
                        n_depth_s = r_depth + DEP_W'(1);
                    end
                end
                SYM_CLOSE_RND: begin
                    if (empty || top != TYPE_RND) begin
                        n_err_s = 1'b1;
                    end else begin
                        add_x     = 1'b1;
                        n_depth_s = hm1;
                    end
                end
                SYM_OPEN_SQR: begin
                    if (full) begin
                        n_err_s = 1'b1;
                    end else begin
                        add_x     = 1'b1;
                        // a round close would also have been legal here
                        add_y     = !empty && (top == TYPE_RND);
                        push      = 1'b1;
                        push_bit  = TYPE_SQR;
                        n_depth_s = r_depth + DEP_W'(1);
                    end
                end
                SYM_CLOSE_SQR: begin
                    if (empty || top != TYPE_SQR) begin
                        n_err_s = 1'b1;
                    end else begin
                        add_x     = 1'b1;
                        dbl_x     = 1'b1;
                        n_depth_s = hm1;
                    end
                end
                default: begin
                    n_err_s = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl    <= HL_W'(1);
            r_pos   <= '0;
            r_depth <= '0;
            r_err   <= 1'b0;
            r_iss   <= '0;
        end else begin
            r_iss.valid  <= acc;
            r_iss.last   <= is_last;
            r_iss.bad    <= n_err_s || (n_depth_s != '0);
            r_iss.add_x  <= add_x;
            r_iss.dbl_x  <= dbl_x;
            r_iss.add_y  <= add_y;
            r_iss.zero_x <= d_x[CMP_W-1];
            r_iss.zero_y <= empty || d_y[CMP_W-1];
            r_iss.sh_x   <= SH_W'(d_x >> 1);
            r_iss.sh_y   <= SH_W'(d_y >> 1);
            if (i_cfg_we) begin
                r_hl    <= cfg_hl;
                r_pos   <= '0;
                r_depth <= '0;
                r_err   <= 1'b0;
            end else if (acc) begin
                if (is_last) begin
                    r_pos   <= '0;
                    r_depth <= '0;
                    r_err   <= 1'b0;
                end else begin
                    r_pos   <= r_pos + POS_W'(1);
                    r_depth <= n_depth_s;
                    r_err   <= n_err_s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && push) begin
            r_stack[r_depth[STK_AW-1:0]] <= push_bit;
        end
    end

    assign o_iss = r_iss;

    `BSR_ASSERT(a_depth_cap, r_depth <= DEP_W'(MAX_PAIRS), "stack depth beyond capacity")
    `BSR_ASSERT(a_last_clears, o_last_acc |=> (r_pos == '0 && r_depth == '0 && !r_err), "sequence state not cleared after last item")

endmodule

// File: rtl/core/bsr_accum.sv
// ----------------------------------------------------------------------------
// bsr_accum: rank accumulator and result queue
// shifts the table words into weights, sums them into the running rank
// and queues one result per sequence
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsr_accum import bsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_last_acc,
    input  t_issue            i_iss,
    input  logic [RANK_W-1:0] i_rd_x,
    input  logic [RANK_W-1:0] i_rd_y,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RANK_W-1:0] o_rank,
    output logic              o_error
);

    logic              r_c_valid;
    logic              r_c_last;
    logic              r_c_bad;
    logic [RANK_W-1:0] r_inc;
    logic [RANK_W-1:0] r_acc;
    logic [RANK_W-1:0] r_q_rank [QUEUE_DEPTH];
    logic              r_q_err  [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wp;
    logic [QA_W-1:0]   r_rp;
    logic [QC_W-1:0]   r_cnt;
    logic [QC_W-1:0]   r_pend;

    logic [RANK_W-1:0] ax;
    logic [RANK_W-1:0] ay;
    logic [RANK_W-1:0] t1;
    logic [RANK_W-1:0] t2;
    logic [RANK_W-1:0] sum;
    logic              push;
    logic              pop;

    assign ax = i_iss.zero_x ? '0 : (i_rd_x << i_iss.sh_x);
    assign ay = i_iss.zero_y ? '0 : (i_rd_y << i_iss.sh_y);
    assign t1 = i_iss.add_x ? ax : '0;
    assign t2 = i_iss.dbl_x ? ax : (i_iss.add_y ? ay : '0);

    assign sum  = r_acc + r_inc;
    assign push = r_c_valid && r_c_last;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_c_last  <= 1'b0;
            r_c_bad   <= 1'b0;
            r_acc     <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_pend    <= '0;
        end else begin
            r_c_valid <= i_iss.valid;
            r_c_last  <= i_iss.last;
            r_c_bad   <= i_iss.bad;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_c_valid) begin
                r_acc <= r_c_last ? '0 : sum;
            end
            if (push) begin
                r_wp <= (r_wp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            r_cnt  <= r_cnt + QC_W'(push) - QC_W'(pop);
            // credits held from the last item's accept until its result leaves
            r_pend <= r_pend + QC_W'(i_last_acc) - QC_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc <= t1 + t2;
        if (push) begin
            r_q_rank[r_wp] <= r_c_bad ? '0 : sum;
            r_q_err[r_wp]  <= r_c_bad;
        end
    end

    assign o_room  = (r_pend < QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rank  = r_q_rank[r_rp];
    assign o_error = r_q_err[r_rp];

    `BSR_ASSERT(a_queue_within_credit, r_cnt <= r_pend, "queued results exceed outstanding credits")
    `BSR_ASSERT(a_push_has_space, push |-> (r_cnt != QC_W'(QUEUE_DEPTH)), "result pushed into full queue")

endmodule

// File: rtl/core/bracket_sequence_rank_core.sv
// ----------------------------------------------------------------------------
// bracket_sequence_rank_core: lexicographic rank of a two-type bracket sequence
// symbols ( < ) < [ < ], one symbol per item, one result per sequence
//
//   channel   dir  tdata                        tuser
//   s_axis    in   [1:0] symbol                 -
//   m_axis    out  [59:0] rank, zero padded     [0] error
//   cfg       in   [4:0] half_length, write enable only
//
// one item per cycle while s_axis_tready is high; each item does two reads of
// the path count ram pair, one in each copy, and a shifted add into the running rank
// the last symbol's result passes the issue and ram read registers, the increment
// register and the result queue before m_axis_tvalid rises; after reset and after
// every cfg write the table fill runs, during which s_axis_tready stays low
// a full two-entry result queue holds back only the last symbol of a
// sequence; other symbols keep flowing while results wait
// ----------------------------------------------------------------------------
module bracket_sequence_rank_core import bsr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [HL_W-1:0]      i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [1:0] symbol
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [59:0] rank
    output logic                 o_m_axis_tuser    // [0] error
);

    t_tbl_wr           tbl_wr;
    t_issue            iss;
    logic              fill_busy;
    logic              room;
    logic              last_acc;
    logic [TAB_AW-1:0] addr_x;
    logic [TAB_AW-1:0] addr_y;
    logic [RANK_W-1:0] rd_x;
    logic [RANK_W-1:0] rd_y;
    logic [RANK_W-1:0] rank;

    bsr_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .o_busy  (fill_busy),
        .o_wr    (tbl_wr)
    );

    bsr_issue u_issue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_busy      (fill_busy),
        .i_valid     (i_s_axis_tvalid),
        .i_symbol    (i_s_axis_tdata[SYM_W-1:0]),
        .i_room      (room),
        .o_ready     (o_s_axis_tready),
        .o_last_acc  (last_acc),
        .o_addr_x    (addr_x),
        .o_addr_y    (addr_y),
        .o_iss       (iss)
    );

    // two copies of the table so both weights come back in the same cycle
    bsr_ram #(
        .WIDTH (RANK_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab_x (
        .i_clk   (i_clk),
        .i_we    (tbl_wr.we),
        .i_waddr (tbl_wr.addr),
        .i_wdata (tbl_wr.data),
        .i_raddr (addr_x),
        .o_rdata (rd_x)
    );

    bsr_ram #(
        .WIDTH (RANK_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab_y (
        .i_clk   (i_clk),
        .i_we    (tbl_wr.we),
        .i_waddr (tbl_wr.addr),
        .i_wdata (tbl_wr.data),
        .i_raddr (addr_y),
        .o_rdata (rd_y)
    );

    bsr_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_we),
        .i_last_acc (last_acc),
        .i_iss      (iss),
        .i_rd_x     (rd_x),
        .i_rd_y     (rd_y),
        .o_room     (room),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_rank     (rank),
        .o_error    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = M_TDATA_W'(rank);

endmodule

// File: tb/bracket_sequence_rank_core_test.sv
// ----------------------------------------------------------------------------
// bracket_sequence_rank_core_test: self-checking bench for the bracket rank core
// streams round and square bracket symbols into the core, predicts the rank and
// error bit of every finished sequence and checks each result in order, over
// several pair counts, with random idling on both streams and a long output stall
// ----------------------------------------------------------------------------
module bracket_sequence_rank_core_test;
    import bsr_pkg::*;

    typedef bit [63:0] t_count;

    typedef struct {
        bit [RANK_W-1:0] rank;
        bit              err;
    } t_rank_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [HL_W-1:0]      i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    bracket_sequence_rank_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // rank predictor state
    t_count       path_count [TAB_ROWS][TAB_COLS];
    logic         open_kind [MAX_PAIRS];
    int           pair_count;
    int           open_depth;
    int           seq_pos;
    bit [RANK_W-1:0] rank_acc;
    bit           seq_broken;
    t_rank_result pending_ranks [$];

    int           mismatch_count;
    int           symbols_sent;
    bit           idle_en;
    int           rx_burst_left;
    int           rx_hold_left;
    t_rank_result oldest_rank;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void build_path_counts();
        for (int i = 0; i < TAB_ROWS; i++)
            for (int j = 0; j < TAB_COLS; j++)
                path_count[i][j] = '0;
        path_count[0][0] = 1;
        for (int i = 1; i <= 2 * pair_count && i < TAB_ROWS; i++) begin
            for (int j = 0; j < TAB_COLS; j++) begin
                path_count[i][j] = (j > 0 ? path_count[i-1][j-1] : t_count'(0))
                    + (j + 1 < TAB_COLS ? path_count[i-1][j+1] : t_count'(0));
            end
        end
    endfunction

    function automatic void clear_sequence();
        open_depth = 0;
        seq_pos    = 0;
        rank_acc   = '0;
        seq_broken = 1'b0;
    endfunction

    // completions of r symbols from height h, each pair round or square
    function automatic t_count completions(int r, int h);
        if (r >= TAB_ROWS || h >= TAB_COLS || r < h)
            return '0;
        return path_count[r][h] << ((r - h) / 2);
    endfunction

    function automatic void predict_symbol(t_symbol sym);
        int     total;
        int     r;
        int     h;
        t_count x;
        t_count y;
        logic   top;
        bit     bad;
        total = 2 * pair_count;
        if (!seq_broken) begin
            r   = total - seq_pos - 1;
            h   = open_depth;
            x   = completions(r, h + 1);
            y   = (h > 0) ? completions(r, h - 1) : t_count'(0);
            top = (h > 0) ? open_kind[h-1] : TYPE_RND;
            case (sym)
                SYM_OPEN_RND: begin
                    if (h >= MAX_PAIRS) begin
                        seq_broken = 1'b1;
                    end else begin
                        open_kind[h] = TYPE_RND;
                        open_depth   = h + 1;
                    end
                end
                SYM_CLOSE_RND: begin
                    if (h == 0 || top != TYPE_RND) begin
                        seq_broken = 1'b1;
                    end else begin
                        rank_acc   = rank_acc + x[RANK_W-1:0];
                        open_depth = h - 1;
                    end
                end
                SYM_OPEN_SQR: begin
                    if (h >= MAX_PAIRS) begin
                        seq_broken = 1'b1;
                    end else begin
                        rank_acc = rank_acc + x[RANK_W-1:0];
                        // a round close would also have fit here
                        if (h > 0 && top == TYPE_RND)
                            rank_acc = rank_acc + y[RANK_W-1:0];
                        open_kind[h] = TYPE_SQR;
                        open_depth   = h + 1;
                    end
                end
                default: begin
                    if (h == 0 || top != TYPE_SQR) begin
                        seq_broken = 1'b1;
                    end else begin
                        rank_acc   = rank_acc + x[RANK_W-1:0] + x[RANK_W-1:0];
                        open_depth = h - 1;
                    end
                end
            endcase
        end
        seq_pos++;
        if (seq_pos >= total) begin
            bad = seq_broken || open_depth != 0;
            pending_ranks.push_back('{rank: bad ? '0 : rank_acc, err: bad});
            clear_sequence();
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_symbol(input t_symbol sym);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W-SYM_W){1'b0}}, sym};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predict_symbol(sym);
        symbols_sent++;
    endtask

    task automatic send_sequence(input t_symbol seq [$]);
        foreach (seq[k])
            send_symbol(seq[k]);
    endtask

    // stop offering and let every pending result drain
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge i_clk);
        // a trailing symbol with no result may still be in the pipe
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_half_length(input logic [HL_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pair_count = (value == 0) ? 1 : (value > MAX_PAIRS) ? MAX_PAIRS : int'(value);
        clear_sequence();
        build_path_counts();
    endtask

    function automatic void make_balanced(int pairs, ref t_symbol seq [$]);
        int   open_now;
        int   left;
        bit   go_open;
        logic kind;
        logic kinds [$];
        seq.delete();
        open_now = 0;
        for (int p = 0; p < 2 * pairs; p++) begin
            left = 2 * pairs - p;
            if (open_now == 0)
                go_open = 1'b1;
            else if (open_now == left)
                go_open = 1'b0;
            else
                go_open = $urandom_range(0, 1);
            if (go_open) begin
                kind = $urandom_range(0, 1) ? TYPE_SQR : TYPE_RND;
                kinds.push_back(kind);
                seq.push_back(kind == TYPE_SQR ? SYM_OPEN_SQR : SYM_OPEN_RND);
                open_now++;
            end else begin
                // innermost open bracket closes first
                kind = kinds[kinds.size() - 1];
                kinds.delete(kinds.size() - 1);
                seq.push_back(kind == TYPE_SQR ? SYM_CLOSE_SQR : SYM_CLOSE_RND);
                open_now--;
            end
        end
    endfunction

    // one symbol of a balanced sequence swapped for another
    function automatic void make_broken(int pairs, ref t_symbol seq [$]);
        int idx;
        make_balanced(pairs, seq);
        idx = $urandom_range(0, seq.size() - 1);
        seq[idx] = t_symbol'((int'(seq[idx]) + $urandom_range(1, 3)) % 4);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_short_sequences();
        t_symbol seq [$];
        idle_en = 1'b0;
        write_half_length(5'd0);
        seq = '{SYM_OPEN_RND, SYM_CLOSE_RND,     // lowest rank
                SYM_OPEN_SQR, SYM_CLOSE_SQR,     // highest rank
                SYM_CLOSE_RND, SYM_OPEN_RND,     // close on empty stack
                SYM_OPEN_RND, SYM_CLOSE_SQR,     // mismatched close
                SYM_OPEN_SQR, SYM_CLOSE_RND,     // mismatched close
                SYM_CLOSE_SQR, SYM_CLOSE_SQR,    // close on empty stack
                SYM_OPEN_RND, SYM_OPEN_SQR};     // left open at the end
        send_sequence(seq);
    endtask

    task automatic test_longest_sequences();
        t_symbol seq [$];
        idle_en = 1'b1;
        write_half_length(5'd31);
        seq.delete();
        for (int k = 0; k < MAX_PAIRS; k++) seq.push_back(SYM_OPEN_SQR);
        for (int k = 0; k < MAX_PAIRS; k++) seq.push_back(SYM_CLOSE_SQR);
        send_sequence(seq);
        seq.delete();
        for (int k = 0; k < MAX_PAIRS; k++) begin
            seq.push_back(SYM_OPEN_RND);
            seq.push_back(SYM_CLOSE_RND);
        end
        send_sequence(seq);
        // stack overflow: an open with the stack already full
        seq.delete();
        for (int k = 0; k < MAX_PAIRS; k++) seq.push_back(SYM_OPEN_SQR);
        seq.push_back(SYM_OPEN_RND);
        for (int k = 0; k < MAX_PAIRS - 1; k++) seq.push_back(SYM_CLOSE_SQR);
        send_sequence(seq);
        write_half_length(5'd17);
        make_balanced(MAX_PAIRS, seq);
        send_sequence(seq);
    endtask

    task automatic test_output_stall();
        t_symbol seq [$];
        idle_en = 1'b0;
        write_half_length(5'd1);
        // first sequence waits out the table fill, then the receiver holds off
        make_balanced(1, seq);
        send_sequence(seq);
        rx_hold_left = 300;
        for (int k = 0; k < 30; k++) begin
            make_balanced(1, seq);
            send_sequence(seq);
        end
        drain_results();
    endtask

    task automatic test_random_phases();
        t_symbol seq [$];
        int      pick;
        int      phase_end;
        while (symbols_sent < 1000) begin
            idle_en = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 2)
                write_half_length(HL_W'($urandom_range(0, 31)));
            else if (pick < 15)
                write_half_length(HL_W'($urandom_range(1, 4)));
            else if (pick < 18)
                write_half_length(HL_W'($urandom_range(5, 10)));
            else
                write_half_length(HL_W'($urandom_range(11, 16)));
            phase_end = symbols_sent + $urandom_range(50, 110);
            while (symbols_sent < phase_end) begin
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    make_balanced(pair_count, seq);
                    send_sequence(seq);
                end else if (pick < 18) begin
                    make_broken(pair_count, seq);
                    send_sequence(seq);
                end else begin
                    repeat ($urandom_range(1, 2 * pair_count))
                        send_symbol(t_symbol'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    task automatic test_steady_stream();
        t_symbol seq [$];
        idle_en = 1'b0;
        write_half_length(5'd3);
        for (int k = 0; k < 15; k++) begin
            make_balanced(pair_count, seq);
            send_sequence(seq);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // output side: random stalls, long hold and result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else if (rx_burst_left > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_burst_left--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_burst_left = $urandom_range(0, 18);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_ranks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: rank %0d error %0b",
                             o_m_axis_tdata[RANK_W-1:0], o_m_axis_tuser);
            end else begin
                oldest_rank = pending_ranks.pop_front();
                if (o_m_axis_tdata[RANK_W-1:0] !== oldest_rank.rank ||
                    o_m_axis_tuser !== oldest_rank.err) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: rank exp %0d got %0d, error exp %0b got %0b",
                                 oldest_rank.rank, o_m_axis_tdata[RANK_W-1:0],
                                 oldest_rank.err, o_m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b1;
        mismatch_count = 0;
        symbols_sent   = 0;
        idle_en        = 1'b0;
        rx_burst_left  = 0;
        rx_hold_left   = 0;
        pair_count     = 1;
        clear_sequence();
        build_path_counts();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_sequences();
        test_longest_sequences();
        test_output_stall();
        test_random_phases();
        test_steady_stream();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_ranks.size() == 0)
            $display("bracket_sequence_rank_core test passed");
        else
            $display("bracket_sequence_rank_core test failed");
        $finish;
    end

    initial begin
        #3200000;
        $display("bracket_sequence_rank_core test failed");
        $finish;
    end

endmodule
